[design/rapc_pkg.sv]
// Shared types and constants for the ROC AUC pair counter.
// No dependencies; rapc_front, rapc_back, the top and the bench refer to it by scoped names.
`timescale 1ns / 1ps

package rapc_pkg;

	localparam int MAX_ITEMS  = 1024;
	localparam int SCORE_BITS = 32;
	localparam int ADDR_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
	localparam int PROD_W     = 2 * CNT_W;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int FRAC_BITS  = 16;
	localparam int AUC_W      = 17;
	localparam int PAIRS_W    = 19;
	localparam int OCNT_W     = 11;
	localparam int STORE_W    = SCORE_BITS + 1;

	// key: score with the sign bit flipped, so an unsigned compare orders it as signed
	typedef struct packed {
		logic [SCORE_BITS-1:0] key;
		logic                  neg;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic [AUC_W-1:0]   auc_q16;
		logic [PAIRS_W-1:0] misordered_pairs;
		logic [OCNT_W-1:0]  positive_count;
		logic [OCNT_W-1:0]  negative_count;
		logic               one_class_only;
		logic               overflowed;
	} result_t;

endpackage

[design/rapc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rapc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/rapc_front.sv]
// Front end: accepts input transfers, forms the compare key and queues items.
// Uses rapc_pkg.
`timescale 1ns / 1ps

module rapc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rapc_pkg::SCORE_BITS-1:0] in_score,
	input  logic                          in_neg,
	input  logic                          in_last,
	output logic                          q_valid,
	input  logic                          q_ready,
	output rapc_pkg::item_t               q_item
);

	rapc_pkg::item_t             entry_q [rapc_pkg::Q_DEPTH];
	logic [rapc_pkg::Q_PTR_W-1:0] wptr_q, rptr_q;
	logic [rapc_pkg::Q_PTR_W:0]   fill_q;
	logic                         push, pop;
	rapc_pkg::item_t              new_item;

	assign in_ready = (fill_q != (rapc_pkg::Q_PTR_W+1)'(rapc_pkg::Q_DEPTH));
	assign q_valid  = (fill_q != '0);
	assign q_item   = entry_q[rptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_comb begin
		new_item.key  = {~in_score[rapc_pkg::SCORE_BITS-1], in_score[rapc_pkg::SCORE_BITS-2:0]};
		new_item.neg  = in_neg;
		new_item.last = in_last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (rapc_pkg::Q_PTR_W+1)'(rapc_pkg::Q_DEPTH))
		else $error("queue fill above depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> !push)
		else $error("push into full queue");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("queue fill lost a push");

endmodule

[design/rapc_back.sv]
// Back end: stores items, counts misordered pairs against stored items,
// and divides out the AUC at the end of a query. Uses rapc_pkg and rapc_ram.
`timescale 1ns / 1ps

module rapc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  rapc_pkg::item_t   q_item,
	output logic              res_valid,
	input  logic              res_ready,
	output rapc_pkg::result_t res
);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_MUL, ST_PREP, ST_DIV, ST_DONE} state_t;

	state_t                         state_q;
	rapc_pkg::item_t                item_q;
	logic [rapc_pkg::CNT_W-1:0]     cnt_q, idx_q, npos_q, nneg_q;
	logic                           ovf_q;
	logic                           rv_s1;
	logic [rapc_pkg::PROD_W-1:0]    pairs_q, tot_q;
	logic [rapc_pkg::PROD_W:0]      rem_q;
	logic [rapc_pkg::AUC_W-1:0]     quo_q;
	logic [3:0]                     step_q;
	logic                           res_valid_q;
	rapc_pkg::result_t              res_q;

	logic                           ram_we;
	logic [rapc_pkg::STORE_W-1:0]   ram_rdata;
	logic [rapc_pkg::SCORE_BITS-1:0] s_key;
	logic                           s_neg, hit;
	logic [rapc_pkg::PROD_W:0]      rem2;
	logic [rapc_pkg::PROD_W-1:0]    diff;
	logic                           full, one_class;
	logic                           res_load;

	assign full      = (cnt_q == rapc_pkg::CNT_W'(rapc_pkg::MAX_ITEMS));
	assign one_class = (npos_q == '0) || (nneg_q == '0);
	assign q_ready   = (state_q == ST_IDLE);
	assign ram_we    = (state_q == ST_SCAN) && (idx_q == cnt_q) && !rv_s1;
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || res_ready);
	assign s_key     = ram_rdata[rapc_pkg::SCORE_BITS-1:0];
	assign s_neg     = ram_rdata[rapc_pkg::SCORE_BITS];
	// new negative vs earlier positive: ties count; new positive vs earlier negative: strict
	assign hit = item_q.neg ? (!s_neg && (s_key <= item_q.key))
	                        : (s_neg && (item_q.key < s_key));
	assign rem2 = {rem_q[rapc_pkg::PROD_W-1:0], 1'b0};
	assign diff = tot_q - pairs_q;

	rapc_ram #(
		.WIDTH(rapc_pkg::STORE_W),
		.DEPTH(rapc_pkg::MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[rapc_pkg::ADDR_W-1:0]),
		.wdata({item_q.neg, item_q.key}),
		.raddr(idx_q[rapc_pkg::ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// read data of the scan is valid in the cycle after its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_SCAN) && (idx_q != cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			npos_q      <= '0;
			nneg_q      <= '0;
			ovf_q       <= 1'b0;
			pairs_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						idx_q  <= '0;
						if (full) begin
							ovf_q   <= 1'b1;
							state_q <= q_item.last ? ST_MUL : ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q != cnt_q) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rv_s1 && hit) pairs_q <= pairs_q + 1'b1;
					if (ram_we) begin
						cnt_q <= cnt_q + 1'b1;
						if (item_q.neg) nneg_q <= nneg_q + 1'b1;
						else            npos_q <= npos_q + 1'b1;
						state_q <= item_q.last ? ST_MUL : ST_IDLE;
					end
				end
				ST_MUL: begin
					tot_q   <= rapc_pkg::PROD_W'(npos_q) * rapc_pkg::PROD_W'(nneg_q);
					quo_q   <= '0;
					state_q <= one_class ? ST_DONE : ST_PREP;
				end
				ST_PREP: begin
					// integer part is 1 only when there are no misordered pairs
					step_q <= '0;
					if (pairs_q == '0) begin
						quo_q <= rapc_pkg::AUC_W'(1);
						rem_q <= '0;
					end else begin
						quo_q <= '0;
						rem_q <= {1'b0, diff};
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rem2 >= {1'b0, tot_q}) begin
						rem_q <= rem2 - {1'b0, tot_q};
						quo_q <= {quo_q[rapc_pkg::AUC_W-2:0], 1'b1};
					end else begin
						rem_q <= rem2;
						quo_q <= {quo_q[rapc_pkg::AUC_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 4'(rapc_pkg::FRAC_BITS - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						res_q.auc_q16          <= quo_q;
						res_q.misordered_pairs <= rapc_pkg::PAIRS_W'(pairs_q);
						res_q.positive_count   <= rapc_pkg::OCNT_W'(npos_q);
						res_q.negative_count   <= rapc_pkg::OCNT_W'(nneg_q);
						res_q.one_class_only   <= one_class;
						res_q.overflowed       <= ovf_q;
						cnt_q       <= '0;
						npos_q      <= '0;
						nneg_q      <= '0;
						pairs_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rapc_pkg::CNT_W'(rapc_pkg::MAX_ITEMS))
		else $error("item count above capacity");
	a_cnt_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (npos_q + nneg_q == cnt_q))
		else $error("class counts disagree with item count");
	a_pairs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |-> (pairs_q <= tot_q))
		else $error("pair count above class product");
	a_one_class_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.one_class_only) |-> (res_q.auc_q16 == '0))
		else $error("one-class result with nonzero AUC");

endmodule

[design/roc_auc_pair_count_top.sv]
// Each item of a query holds the back end for a scan with one store read per earlier item;
// a last item adds a multiply and a 16-step divide (skipped when a class is empty). The back end
// takes no new item until it is through with the last; a dropped item skips the scan.
// A four-entry queue lets the input side run ahead of that scan.
// Reset (arst_n low, asynchronous): queue emptied, counts and flags cleared, no result held.
// Top level of the ROC AUC pair counter; uses rapc_pkg, rapc_front, rapc_back.
`timescale 1ns / 1ps

module roc_auc_pair_count_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] score
	input  logic        s_axis_tuser,  // [0] is_negative
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [16:0] auc_q16, [35:17] misordered_pairs, [46:36] positive_count,
	// [57:47] negative_count, [58] one_class_only, [59] overflowed, [63:60] zero
	output logic [63:0] m_axis_tdata
);

	logic              q_valid, q_ready;
	rapc_pkg::item_t   q_item;
	rapc_pkg::result_t res;

	rapc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_score(s_axis_tdata[rapc_pkg::SCORE_BITS-1:0]),
		.in_neg  (s_axis_tuser),
		.in_last (s_axis_tlast),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	rapc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = {4'b0, res.overflowed, res.one_class_only, res.negative_count,
		res.positive_count, res.misordered_pairs, res.auc_q16};

endmodule

[tb/tb.sv]
// Self-checking bench for roc_auc_pair_count_top: queries of scored, labeled items go in,
// per-query AUC results come out and are checked against an in-bench pair-count predictor.
// Depends on rapc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [31:0] score;
		logic        neg;
		logic        last;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;

	roc_auc_pair_count_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	stim_t             pending_items[$];
	rapc_pkg::result_t expected_aucs[$];
	int      errors = 0;
	bit      stim_done = 0;

	// predictor state: one query's stored items
	logic [31:0]    q_key[rapc_pkg::MAX_ITEMS];
	logic           q_neg[rapc_pkg::MAX_ITEMS];
	int             q_count = 0;
	bit             q_over = 0;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// accept one item into the predictor, push a result on a last item
	task automatic predict_auc(input stim_t it);
		longint npos, nneg, pairs, total, auc;
		rapc_pkg::result_t r;
		npos = 0; nneg = 0; pairs = 0; auc = 0;
		if (q_count < rapc_pkg::MAX_ITEMS) begin
			q_key[q_count] = it.score ^ 32'h8000_0000;
			q_neg[q_count] = it.neg;
			q_count++;
		end else begin
			q_over = 1;
		end
		if (!it.last) return;
		for (int j = 0; j < q_count; j++) begin
			if (!q_neg[j]) begin
				npos++;
			end else begin
				nneg++;
				for (int i = 0; i < q_count; i++)
					if (!q_neg[i] && i != j &&
					    (q_key[i] < q_key[j] || (q_key[i] == q_key[j] && i < j)))
						pairs++;
			end
		end
		if (npos != 0 && nneg != 0) begin
			total = npos * nneg;
			auc = ((total - pairs) << 16) / total;
		end
		r.auc_q16          = auc[rapc_pkg::AUC_W-1:0];
		r.misordered_pairs = pairs[rapc_pkg::PAIRS_W-1:0];
		r.positive_count   = npos[rapc_pkg::OCNT_W-1:0];
		r.negative_count   = nneg[rapc_pkg::OCNT_W-1:0];
		r.one_class_only   = (npos == 0 || nneg == 0);
		r.overflowed       = q_over;
		expected_aucs.push_back(r);
		q_count = 0;
		q_over = 0;
	endtask

	task automatic add_item(input logic [31:0] s, input logic n, input logic l);
		stim_t it;
		it.score = s; it.neg = n; it.last = l;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] rand_score(input int flavor);
		case (flavor)
			0: rand_score = 32'h8000_0000;
			1: rand_score = 32'h7fff_ffff;
			2: rand_score = $urandom_range(7, 0) - 4;
			default: rand_score = $urandom;
		endcase
	endfunction

	initial begin
		int len, kind, items;
		// directed: extremes, ties both ways, one-class queries, single item
		add_item(32'h8000_0000, 1'b0, 1'b0);
		add_item(32'h7fff_ffff, 1'b1, 1'b1);
		add_item(32'h7fff_ffff, 1'b0, 1'b0);
		add_item(32'h8000_0000, 1'b1, 1'b1);
		add_item(32'h0000_1000, 1'b0, 1'b0);
		add_item(32'h0000_1000, 1'b1, 1'b0);
		add_item(32'h0000_1000, 1'b1, 1'b0);
		add_item(32'h0000_1000, 1'b0, 1'b1);
		add_item(32'hffff_ffff, 1'b0, 1'b1);
		add_item(32'h0000_0000, 1'b1, 1'b0);
		add_item(32'h5555_5555, 1'b1, 1'b0);
		add_item(32'haaaa_aaaa, 1'b1, 1'b1);
		add_item(32'h0001_0000, 1'b0, 1'b0);
		add_item(32'hfffe_0000, 1'b1, 1'b0);
		add_item(32'h0000_0001, 1'b0, 1'b0);
		add_item(32'h0000_0001, 1'b1, 1'b1);
		// random: short queries, some forced to a single class
		items = 0;
		while (items < 700) begin
			kind = $urandom_range(99, 0);
			len = $urandom_range(12, 1);
			for (int k = 0; k < len; k++)
				add_item(rand_score($urandom_range(5, 0)),
				         (kind % 10 == 3) ? 1'b0 : (kind % 10 == 4) ? 1'b1 :
				         1'($urandom_range(1, 0)),
				         k == len - 1);
			items += len;
		end
		stim_done = 1;
	end

	// driver: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_auc(pending_items.pop_front());
				if (burst_left > 0) burst_left--;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(20, 1);
					gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
				end
				if (gap_left > 0 && burst_left == 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() > 0 && stim_done) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_items[0].score;
					s_axis_tuser  <= pending_items[0].neg;
					s_axis_tlast  <= pending_items[0].last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
				if (burst_left == 0 && gap_left == 0) burst_left = 0;
			end
		end
	end

	// monitor plus receiver stall pattern
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		rapc_pkg::result_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			stall_phase = (stall_phase + 1) % 97;
			m_axis_tready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(2, 0) != 0);
			if (m_axis_tvalid && m_axis_tready) begin
				got.auc_q16          = m_axis_tdata[16:0];
				got.misordered_pairs = m_axis_tdata[35:17];
				got.positive_count   = m_axis_tdata[46:36];
				got.negative_count   = m_axis_tdata[57:47];
				got.one_class_only   = m_axis_tdata[58];
				got.overflowed       = m_axis_tdata[59];
				if (m_axis_tdata[63:60] != 4'd0) begin
					$error("pad bits: expected 0 actual %0h", m_axis_tdata[63:60]);
					errors++;
				end
				if (expected_aucs.size() == 0) begin
					$error("unexpected result %0h", m_axis_tdata);
					errors++;
				end else begin
					want = expected_aucs.pop_front();
					if (got.auc_q16 != want.auc_q16) begin
						$error("auc_q16: expected %0d actual %0d", want.auc_q16, got.auc_q16);
						errors++;
					end
					if (got.misordered_pairs != want.misordered_pairs) begin
						$error("misordered_pairs: expected %0d actual %0d",
						       want.misordered_pairs, got.misordered_pairs);
						errors++;
					end
					if (got.positive_count != want.positive_count) begin
						$error("positive_count: expected %0d actual %0d",
						       want.positive_count, got.positive_count);
						errors++;
					end
					if (got.negative_count != want.negative_count) begin
						$error("negative_count: expected %0d actual %0d",
						       want.negative_count, got.negative_count);
						errors++;
					end
					if (got.one_class_only != want.one_class_only) begin
						$error("one_class_only: expected %0d actual %0d",
						       want.one_class_only, got.one_class_only);
						errors++;
					end
					if (got.overflowed != want.overflowed) begin
						$error("overflowed: expected %0d actual %0d",
						       want.overflowed, got.overflowed);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (pending_items.size() > 0 || expected_aucs.size() > 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors == 0 && expected_aucs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// short queries with input gaps and output stalls finish well inside this
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
